// ----- rtl/sbrst_pkg.sv -----
// Shared types, constants and saturation helpers for the swept box slab test.
`timescale 1ns / 1ps
`default_nettype none
package sbrst_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd2;

  localparam int DIV_NUM_W  = 49;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_STAGES = DIV_NUM_W;

  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;

  typedef enum logic [2:0] {
    NRM_NONE    = 3'd0,
    NRM_PLUS_X  = 3'd1,
    NRM_MINUS_X = 3'd2,
    NRM_PLUS_Y  = 3'd3,
    NRM_MINUS_Y = 3'd4
  } normal_t;

  typedef struct packed {
    logic [32:0]        lo_mag;
    logic [32:0]        hi_mag;
    logic               lo_neg;
    logic               hi_neg;
    logic [31:0]        den_mag;
    logic signed [31:0] dir;
    logic signed [31:0] origin;
    logic               dzero;
    logic               in_slab;
  } axis_t;

  typedef struct packed {
    logic  zero_vel;
    axis_t x;
    axis_t y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] dir;
    logic signed [31:0] origin;
    logic               dzero;
    logic               in_slab;
    logic               lo_neg;
    logic               hi_neg;
  } side_axis_t;

  typedef struct packed {
    logic       zero_vel;
    side_axis_t x;
    side_axis_t y;
  } side_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] == v[31]) return v[31:0];
    else if (v[32]) return Q_MIN;
    else return Q_MAX;
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if ((&v[63:31]) || !(|v[63:31])) return v[31:0];
    else if (v[63]) return Q_MIN;
    else return Q_MAX;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sbrst_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module sbrst_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [sbrst_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [sbrst_pkg::DIV_DEN_W-1:0] den,
  output logic      [sbrst_pkg::DIV_NUM_W-1:0] quo
);
  import sbrst_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q [DIV_STAGES];
  logic [DIV_NUM_W-1:0] num_q [DIV_STAGES];
  logic [DIV_NUM_W-1:0] quo_q [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_NUM_W-1:0] num_in;
    logic [DIV_NUM_W-1:0] quo_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, num_in[DIV_NUM_W-1]};
    assign take  = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= take ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        num_q[k] <= {num_in[DIV_NUM_W-2:0], 1'b0};
        quo_q[k] <= {quo_in[DIV_NUM_W-2:0], take};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/sbrst_fifo.sv -----
// Short request queue between the setup front and the slab back end.
`timescale 1ns / 1ps
`default_nettype none
module sbrst_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sbrst_pkg::item_t din,
  input  wire logic             pop,
  output sbrst_pkg::item_t      dout,
  output logic                  full,
  output logic                  empty
);
  import sbrst_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sbrst_front.sv -----
// Front end: accept requests, build slab bounds, ray origin and direction.
`timescale 1ns / 1ps
`default_nettype none
module sbrst_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic        [30:0] time_step,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] mover_pos_x,
  input  wire logic signed [31:0] mover_pos_y,
  input  wire logic        [30:0] mover_size_x,
  input  wire logic        [30:0] mover_size_y,
  input  wire logic signed [31:0] mover_vel_x,
  input  wire logic signed [31:0] mover_vel_y,
  input  wire logic signed [31:0] goal_pos_x,
  input  wire logic signed [31:0] goal_pos_y,
  input  wire logic        [30:0] goal_size_x,
  input  wire logic        [30:0] goal_size_y,
  input  wire logic               full,
  output logic                    push,
  output sbrst_pkg::item_t        item
);
  import sbrst_pkg::*;

  logic fen;
  logic f1_v, f2_v, f3_v, f4_v;

  logic        [29:0] h_x, h_y;
  logic signed [32:0] lo_x_w, lo_y_w, org_x_w, org_y_w;
  logic        [31:0] span_x_w, span_y_w;
  logic signed [63:0] prod_x_w, prod_y_w;

  logic signed [31:0] f1_lo_x, f1_lo_y, f1_org_x, f1_org_y;
  logic        [30:0] f1_span_x, f1_span_y;
  logic signed [63:0] f1_prod_x, f1_prod_y;
  logic               f1_zv;

  logic signed [32:0] hi_x_w, hi_y_w;
  logic signed [63:0] dir_x_w, dir_y_w;

  logic signed [31:0] f2_lo_x, f2_lo_y, f2_hi_x, f2_hi_y;
  logic signed [31:0] f2_org_x, f2_org_y, f2_dir_x, f2_dir_y;
  logic               f2_zv;

  logic signed [32:0] f3_dlo_x, f3_dhi_x, f3_dlo_y, f3_dhi_y;
  logic signed [31:0] f3_org_x, f3_org_y, f3_dir_x, f3_dir_y;
  logic               f3_zv;

  item_t item_w;

  assign fen      = !f4_v || !full;
  assign in_ready = fen;
  assign push     = f4_v && !full;

  assign h_x      = mover_size_x[30:1];
  assign h_y      = mover_size_y[30:1];
  assign lo_x_w   = {goal_pos_x[31], goal_pos_x} - {3'b000, h_x};
  assign lo_y_w   = {goal_pos_y[31], goal_pos_y} - {3'b000, h_y};
  assign org_x_w  = {mover_pos_x[31], mover_pos_x} + {3'b000, h_x};
  assign org_y_w  = {mover_pos_y[31], mover_pos_y} + {3'b000, h_y};
  assign span_x_w = {1'b0, goal_size_x} + {1'b0, mover_size_x};
  assign span_y_w = {1'b0, goal_size_y} + {1'b0, mover_size_y};
  assign prod_x_w = mover_vel_x * $signed({1'b0, time_step});
  assign prod_y_w = mover_vel_y * $signed({1'b0, time_step});

  assign hi_x_w  = {f1_lo_x[31], f1_lo_x} + {2'b00, f1_span_x};
  assign hi_y_w  = {f1_lo_y[31], f1_lo_y} + {2'b00, f1_span_y};
  assign dir_x_w = f1_prod_x >>> 16;
  assign dir_y_w = f1_prod_y >>> 16;

  always_comb begin
    item_w.zero_vel  = f3_zv;
    item_w.x.lo_mag  = f3_dlo_x[32] ? 33'(-f3_dlo_x) : f3_dlo_x;
    item_w.x.hi_mag  = f3_dhi_x[32] ? 33'(-f3_dhi_x) : f3_dhi_x;
    item_w.x.lo_neg  = f3_dlo_x[32] ^ f3_dir_x[31];
    item_w.x.hi_neg  = f3_dhi_x[32] ^ f3_dir_x[31];
    item_w.x.den_mag = f3_dir_x[31] ? 32'(-f3_dir_x) : f3_dir_x;
    item_w.x.dir     = f3_dir_x;
    item_w.x.origin  = f3_org_x;
    item_w.x.dzero   = f3_dir_x == '0;
    item_w.x.in_slab = f3_dlo_x[32] && !f3_dhi_x[32] && (f3_dhi_x != '0);
    item_w.y.lo_mag  = f3_dlo_y[32] ? 33'(-f3_dlo_y) : f3_dlo_y;
    item_w.y.hi_mag  = f3_dhi_y[32] ? 33'(-f3_dhi_y) : f3_dhi_y;
    item_w.y.lo_neg  = f3_dlo_y[32] ^ f3_dir_y[31];
    item_w.y.hi_neg  = f3_dhi_y[32] ^ f3_dir_y[31];
    item_w.y.den_mag = f3_dir_y[31] ? 32'(-f3_dir_y) : f3_dir_y;
    item_w.y.dir     = f3_dir_y;
    item_w.y.origin  = f3_org_y;
    item_w.y.dzero   = f3_dir_y == '0;
    item_w.y.in_slab = f3_dlo_y[32] && !f3_dhi_y[32] && (f3_dhi_y != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      f4_v <= 1'b0;
    end else if (fen) begin
      f1_v <= in_valid;
      f2_v <= f1_v;
      f3_v <= f2_v;
      f4_v <= f3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_lo_x   <= sat33(lo_x_w);
      f1_lo_y   <= sat33(lo_y_w);
      f1_org_x  <= sat33(org_x_w);
      f1_org_y  <= sat33(org_y_w);
      f1_span_x <= span_x_w[31] ? 31'h7fff_ffff : span_x_w[30:0];
      f1_span_y <= span_y_w[31] ? 31'h7fff_ffff : span_y_w[30:0];
      f1_prod_x <= prod_x_w;
      f1_prod_y <= prod_y_w;
      f1_zv     <= (mover_vel_x == '0) && (mover_vel_y == '0);

      f2_lo_x  <= f1_lo_x;
      f2_lo_y  <= f1_lo_y;
      f2_hi_x  <= sat33(hi_x_w);
      f2_hi_y  <= sat33(hi_y_w);
      f2_org_x <= f1_org_x;
      f2_org_y <= f1_org_y;
      f2_dir_x <= sat64(dir_x_w);
      f2_dir_y <= sat64(dir_y_w);
      f2_zv    <= f1_zv;

      f3_dlo_x <= {f2_lo_x[31], f2_lo_x} - {f2_org_x[31], f2_org_x};
      f3_dhi_x <= {f2_hi_x[31], f2_hi_x} - {f2_org_x[31], f2_org_x};
      f3_dlo_y <= {f2_lo_y[31], f2_lo_y} - {f2_org_y[31], f2_org_y};
      f3_dhi_y <= {f2_hi_y[31], f2_hi_y} - {f2_org_y[31], f2_org_y};
      f3_org_x <= f2_org_x;
      f3_org_y <= f2_org_y;
      f3_dir_x <= f2_dir_x;
      f3_dir_y <= f2_dir_y;
      f3_zv    <= f2_zv;

      item <= item_w;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sbrst_back.sv -----
// Back end: slab divisions, near/far ordering, window check and contact point.
`timescale 1ns / 1ps
`default_nettype none
module sbrst_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] window_low,
  input  wire logic signed [31:0] window_high,
  input  wire logic               empty,
  input  wire sbrst_pkg::item_t   item,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic signed      [31:0] entry_time,
  output logic signed      [31:0] contact_x,
  output logic signed      [31:0] contact_y,
  output logic             [2:0]  face_normal
);
  import sbrst_pkg::*;

  function automatic logic signed [31:0] sat_quo(input logic [DIV_NUM_W-1:0] mag,
                                                 input logic neg);
    if (neg) begin
      if (mag > DIV_NUM_W'(33'h0_8000_0000)) return Q_MIN;
      else return 32'(-mag[31:0]);
    end else begin
      if (mag > DIV_NUM_W'(33'h0_7fff_ffff)) return Q_MAX;
      else return mag[31:0];
    end
  endfunction

  logic en;
  side_t side_w;
  logic [DIV_NUM_W-1:0] q_lo_x, q_hi_x, q_lo_y, q_hi_y;
  logic [DIV_STAGES-1:0] vld_q;
  side_t side_q [DIV_STAGES];
  side_t sd;

  logic               c1_v;
  logic signed [31:0] c1_a_x, c1_b_x, c1_a_y, c1_b_y;
  side_t              c1_sd;

  logic               c2_v, c2_miss;
  logic signed [31:0] c2_n_x, c2_f_x, c2_n_y, c2_f_y;
  logic signed [31:0] c2_dx, c2_dy, c2_ox, c2_oy;

  logic               c3_v, c3_miss;
  logic signed [31:0] c3_tn, c3_tf, c3_dx, c3_dy, c3_ox, c3_oy;
  normal_t            c3_nrm, nrm_w;

  logic               c4_v, c4_miss, c4_hit;
  logic signed [31:0] c4_tn, c4_ox, c4_oy;
  logic signed [63:0] c4_px, c4_py;
  normal_t            c4_nrm;

  logic signed [63:0] sum_x_w, sum_y_w;

  assign en  = !out_valid || out_ready;
  assign pop = en && !empty;

  always_comb begin
    side_w.zero_vel  = item.zero_vel;
    side_w.x.dir     = item.x.dir;
    side_w.x.origin  = item.x.origin;
    side_w.x.dzero   = item.x.dzero;
    side_w.x.in_slab = item.x.in_slab;
    side_w.x.lo_neg  = item.x.lo_neg;
    side_w.x.hi_neg  = item.x.hi_neg;
    side_w.y.dir     = item.y.dir;
    side_w.y.origin  = item.y.origin;
    side_w.y.dzero   = item.y.dzero;
    side_w.y.in_slab = item.y.in_slab;
    side_w.y.lo_neg  = item.y.lo_neg;
    side_w.y.hi_neg  = item.y.hi_neg;
  end

  sbrst_div u_div_lo_x (.clk, .en, .num({item.x.lo_mag, 16'h0000}),
                        .den(item.x.den_mag), .quo(q_lo_x));
  sbrst_div u_div_hi_x (.clk, .en, .num({item.x.hi_mag, 16'h0000}),
                        .den(item.x.den_mag), .quo(q_hi_x));
  sbrst_div u_div_lo_y (.clk, .en, .num({item.y.lo_mag, 16'h0000}),
                        .den(item.y.den_mag), .quo(q_lo_y));
  sbrst_div u_div_hi_y (.clk, .en, .num({item.y.hi_mag, 16'h0000}),
                        .den(item.y.den_mag), .quo(q_hi_y));

  assign sd = side_q[DIV_STAGES-1];

  always_comb begin
    nrm_w = NRM_NONE;
    priority if (c2_n_x > c2_n_y) begin
      nrm_w = c2_dx[31] ? NRM_PLUS_X : NRM_MINUS_X;
    end else if (c2_n_x < c2_n_y) begin
      nrm_w = c2_dy[31] ? NRM_PLUS_Y : NRM_MINUS_Y;
    end else begin
      nrm_w = NRM_NONE;
    end
  end

  assign sum_x_w = $signed({{32{c4_ox[31]}}, c4_ox}) + (c4_px >>> 16);
  assign sum_y_w = $signed({{32{c4_oy[31]}}, c4_oy}) + (c4_py >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q     <= '0;
      c1_v      <= 1'b0;
      c2_v      <= 1'b0;
      c3_v      <= 1'b0;
      c4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[DIV_STAGES-2:0], !empty};
      c1_v      <= vld_q[DIV_STAGES-1];
      c2_v      <= c1_v;
      c3_v      <= c2_v;
      c4_v      <= c3_v;
      out_valid <= c4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_w;
      for (int k = 1; k < DIV_STAGES; k++) side_q[k] <= side_q[k-1];

      c1_a_x <= sat_quo(q_lo_x, sd.x.lo_neg);
      c1_b_x <= sat_quo(q_hi_x, sd.x.hi_neg);
      c1_a_y <= sat_quo(q_lo_y, sd.y.lo_neg);
      c1_b_y <= sat_quo(q_hi_y, sd.y.hi_neg);
      c1_sd  <= sd;

      if (c1_sd.x.dzero) begin
        c2_n_x <= Q_MIN;
        c2_f_x <= Q_MAX;
      end else begin
        c2_n_x <= (c1_a_x > c1_b_x) ? c1_b_x : c1_a_x;
        c2_f_x <= (c1_a_x > c1_b_x) ? c1_a_x : c1_b_x;
      end
      if (c1_sd.y.dzero) begin
        c2_n_y <= Q_MIN;
        c2_f_y <= Q_MAX;
      end else begin
        c2_n_y <= (c1_a_y > c1_b_y) ? c1_b_y : c1_a_y;
        c2_f_y <= (c1_a_y > c1_b_y) ? c1_a_y : c1_b_y;
      end
      c2_miss <= c1_sd.zero_vel || (c1_sd.x.dzero && !c1_sd.x.in_slab)
                 || (c1_sd.y.dzero && !c1_sd.y.in_slab);
      c2_dx <= c1_sd.x.dir;
      c2_dy <= c1_sd.y.dir;
      c2_ox <= c1_sd.x.origin;
      c2_oy <= c1_sd.y.origin;

      c3_tn   <= (c2_n_x > c2_n_y) ? c2_n_x : c2_n_y;
      c3_tf   <= (c2_f_x < c2_f_y) ? c2_f_x : c2_f_y;
      c3_miss <= c2_miss || (c2_n_x > c2_f_y) || (c2_n_y > c2_f_x);
      c3_nrm  <= nrm_w;
      c3_dx   <= c2_dx;
      c3_dy   <= c2_dy;
      c3_ox   <= c2_ox;
      c3_oy   <= c2_oy;

      c4_miss <= c3_miss || c3_tf[31];
      c4_px   <= c3_dx * c3_tn;
      c4_py   <= c3_dy * c3_tn;
      c4_hit  <= (c3_tn >= window_low) && (c3_tn < window_high);
      c4_tn   <= c3_tn;
      c4_nrm  <= c3_nrm;
      c4_ox   <= c3_ox;
      c4_oy   <= c3_oy;

      if (c4_miss) begin
        hit         <= 1'b0;
        entry_time  <= '0;
        contact_x   <= '0;
        contact_y   <= '0;
        face_normal <= NRM_NONE;
      end else begin
        hit         <= c4_hit;
        entry_time  <= c4_tn;
        contact_x   <= sat64(sum_x_w);
        contact_y   <= sat64(sum_y_w);
        face_normal <= c4_nrm;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/swept_box_ray_slab_test.sv -----
// Swept box versus fixed box collision test, 2D, Q16.16: top level.
//
// Requests enter on in_valid/in_ready, one per cycle while in_ready is high,
// each carrying a moving box (corner, size, velocity) and a fixed target
// box. Every request yields exactly one result on out_valid/out_ready, in
// request order. With no stall a request passes four setup stages (the
// accepting edge loads the first), the request queue, 49 divider stages
// (one quotient bit per stage, set by the 49-bit dividend) and five combine
// and output stages. Throughput is one request per cycle when nothing stalls.
// The front end and the back end stall separately through a short request
// queue; when the receiver holds out_ready low the back end freezes, the
// queue fills and in_ready drops once it is full.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at the next
// edge; the user must make them only while the block is idle, which the
// block itself does not enforce. Reset clears all pipeline valids and the
// queue and sets time_step to 1.0, window to [0, 1.0).
`timescale 1ns / 1ps
`default_nettype none
module swept_box_ray_slab_test #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] mover_pos_x,
  input  wire logic signed [31:0] mover_pos_y,
  input  wire logic        [30:0] mover_size_x,
  input  wire logic        [30:0] mover_size_y,
  input  wire logic signed [31:0] mover_vel_x,
  input  wire logic signed [31:0] mover_vel_y,
  input  wire logic signed [31:0] goal_pos_x,
  input  wire logic signed [31:0] goal_pos_y,
  input  wire logic        [30:0] goal_size_x,
  input  wire logic        [30:0] goal_size_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic signed      [31:0] entry_time,
  output logic signed      [31:0] contact_x,
  output logic signed      [31:0] contact_y,
  output logic             [2:0]  face_normal
);
  import sbrst_pkg::*;

  logic        [30:0] time_step;
  logic signed [31:0] window_low;
  logic signed [31:0] window_high;

  logic  push, pop, full, empty;
  item_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= 31'd65536;
      window_low  <= 32'sd0;
      window_high <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_STEP:   time_step   <= cfg_data[30:0];
        CFG_WINDOW_LOW:  window_low  <= cfg_data;
        CFG_WINDOW_HIGH: window_high <= cfg_data;
        default: ;
      endcase
    end
  end

  sbrst_front u_front (
    .clk, .rst, .time_step, .in_valid, .in_ready,
    .mover_pos_x, .mover_pos_y, .mover_size_x, .mover_size_y,
    .mover_vel_x, .mover_vel_y, .goal_pos_x, .goal_pos_y,
    .goal_size_x, .goal_size_y,
    .full, .push, .item(q_in)
  );

  sbrst_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst, .push, .din(q_in), .pop, .dout(q_out), .full, .empty
  );

  sbrst_back u_back (
    .clk, .rst, .window_low, .window_high, .empty, .item(q_out), .pop,
    .out_valid, .out_ready, .hit, .entry_time, .contact_x, .contact_y,
    .face_normal
  );

endmodule
`default_nettype wire

// ----- rtl/sbrst_checker.sv -----
// Port-level checks for the swept box slab test, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sbrst_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               hit,
  input wire logic signed [31:0] entry_time,
  input wire logic signed [31:0] contact_x,
  input wire logic signed [31:0] contact_y,
  input wire logic        [2:0]  face_normal
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_reset_frees_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(entry_time)
      && $stable(contact_x) && $stable(contact_y) && $stable(face_normal))
    else $error("stalled result changed");

  a_normal_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> face_normal <= 3'd4)
    else $error("face_normal out of range");

endmodule

bind swept_box_ray_slab_test sbrst_checker u_sbrst_checker (.*);
`default_nettype wire
